// ----- rtl/lts_pkg.sv -----
// Shared constants and request codes for the per-type latency statistics block.
`timescale 1ns / 1ps
package lts_pkg;

  localparam int DEF_NUM_TYPES = 64;
  localparam int DEF_TIME_BITS = 48;

  localparam int CNT_W  = 32;
  localparam int SUM_W  = 64;
  localparam int OUT_W  = 48;
  localparam int TYPE_W = 8;
  localparam int STAT_W = 6;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [1:0] REQ_IMMEDIATE = 2'd0;
  localparam logic [1:0] REQ_DEFERRED  = 2'd1;
  localparam logic [1:0] REQ_READ      = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_STATUS_TYPE = 3'd0;

endpackage

// ----- rtl/lts_div.sv -----
// Iterative restoring divider: 64-bit sum by 32-bit count, one quotient bit per cycle.
`timescale 1ns / 1ps
module lts_div
  import lts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem, dvd[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = !diff[CNT_W];
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (running) begin
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd <= {dvd[SUM_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/per_type_latency_statistics.sv -----
// Top level: per-type statistics memory, update sequencer and averaging dividers.
`timescale 1ns / 1ps
// A command is accepted at a rising edge with start high and busy low. Request
// codes: 0 records an immediate completion, 1 counts a deferred completion,
// 2 (and the unused code 3) only reads the statistics of event_type.
// Every command yields one result transfer: done is high for one cycle with
// the statistics of event_type as they stand after the update, plus the
// global totals. The receiver cannot stall; the result is dropped if unused.
// Per-type state lives in one synchronous memory, read on acceptance and
// written back once per recorded immediate completion. A command passes
// through read, time adjustment and write-back, then starts the dividers
// for the two 64-by-32-bit averages, computed one quotient bit per cycle
// side by side, and then registers the result. An out-of-range type skips
// the dividers. Busy falls together with done, so a new command can be
// offered while done is high. Reset clears the per-entry valid flags at
// once, so every type reads as empty; totals, status history and the status
// type register go to zero. The user must write the status type register
// over the APB port only while busy is low; the block does not enforce it.
module per_type_latency_statistics
  import lts_pkg::*;
#(
  parameter int NUM_TYPES = DEF_NUM_TYPES,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [TYPE_W-1:0]  event_type,
  input  logic [OUT_W-1:0]   creation_time,
  input  logic [OUT_W-1:0]   start_time,
  input  logic [OUT_W-1:0]   completion_time,
  output logic               done,
  output logic               type_valid,
  output logic [CNT_W-1:0]   executed_count,
  output logic [OUT_W-1:0]   avg_queue,
  output logic [OUT_W-1:0]   min_queue,
  output logic [OUT_W-1:0]   max_queue,
  output logic [OUT_W-1:0]   avg_exec,
  output logic [OUT_W-1:0]   min_exec,
  output logic [OUT_W-1:0]   max_exec,
  output logic [CNT_W-1:0]   total_immediate,
  output logic [CNT_W-1:0]   total_deferred
);

  localparam int TB    = TIME_BITS;
  localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'((128'(1) << TIME_BITS) - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_ADJ  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DGO  = 3'd4;
  localparam logic [2:0] S_DWT  = 3'd5;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] qsum;
    logic [TB-1:0]    qmin;
    logic [TB-1:0]    qmax;
    logic [SUM_W-1:0] esum;
    logic [TB-1:0]    emin;
    logic [TB-1:0]    emax;
  } entry_t;

  logic [2:0]         state;
  logic [STAT_W-1:0]  status_idx;
  logic [CNT_W-1:0]   imm_total;
  logic [CNT_W-1:0]   def_total;
  logic [TB-1:0]      ls_start;
  logic [TB-1:0]      ls_done;
  logic [TB-1:0]      ls_exec;

  // Latched command.
  logic [1:0]         req;
  logic               tvalid;
  logic               is_status;
  logic [IDX_W-1:0]   idx;
  logic [TB-1:0]      cre;
  logic [TB-1:0]      sta;
  logic [TB-1:0]      fin;

  logic [TB-1:0]      qt0;
  logic [TB-1:0]      qt;
  logic [TB-1:0]      et;
  logic [TB-1:0]      ded;
  logic               adj;

  entry_t             mem [NUM_TYPES];
  logic [NUM_TYPES-1:0] ent_vld;
  entry_t             rd_data;
  logic               rd_vld;
  entry_t             old_ent;
  entry_t             new_ent;
  entry_t             ent;

  logic               accept;
  logic               cfg_wr;
  logic               record;
  logic               first;
  logic [SUM_W:0]     qsum_add;
  logic [SUM_W:0]     esum_add;

  logic               div_start;
  logic               qdiv_done;
  logic               ediv_done;
  logic [SUM_W-1:0]   qquo;
  logic [SUM_W-1:0]   equo;

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_STATUS_TYPE);
  assign prdata = (paddr == ADDR_STATUS_TYPE) ? DATA_W'(status_idx) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      status_idx <= '0;
    end else if (cfg_wr) begin
      status_idx <= pwdata[STAT_W-1:0];
    end
  end

  // Memory port: one registered read at acceptance, one write-back in the update step for a recorded completion.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[event_type[IDX_W-1:0]];
    end
    if (state == S_UPD && record) begin
      mem[idx] <= new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (state == S_UPD && record) begin
      ent_vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_vld    <= ent_vld[event_type[IDX_W-1:0]];
      req       <= req_type;
      tvalid    <= (9'(event_type) < 9'(NUM_TYPES));
      is_status <= (event_type == TYPE_W'(status_idx));
      idx       <= event_type[IDX_W-1:0];
      cre       <= TB'(creation_time);
      sta       <= TB'(start_time);
      fin       <= TB'(completion_time);
    end
  end

  // Raw differences and the overlap with the last status item's execution.
  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      qt0 <= (sta > cre) ? sta - cre : '0;
      et  <= (fin > sta) ? fin - sta : '0;
      adj <= !is_status && (ls_done > cre);
      ded <= (ls_start >= cre) ? ls_exec : ls_done - cre;
    end
    if (state == S_ADJ) begin
      if (adj) begin
        qt <= (qt0 > ded) ? qt0 - ded : '0;
      end else begin
        qt <= qt0;
      end
    end
  end

  assign record  = (req == REQ_IMMEDIATE) && tvalid;
  assign old_ent = rd_vld ? rd_data : '0;

  always_comb begin
    new_ent     = old_ent;
    new_ent.cnt = (old_ent.cnt == '1) ? old_ent.cnt : old_ent.cnt + 1'b1;
    qsum_add    = {1'b0, old_ent.qsum} + (SUM_W + 1)'(qt);
    esum_add    = {1'b0, old_ent.esum} + (SUM_W + 1)'(et);
    new_ent.qsum = qsum_add[SUM_W] ? '1 : qsum_add[SUM_W-1:0];
    new_ent.esum = esum_add[SUM_W] ? '1 : esum_add[SUM_W-1:0];
    first = (new_ent.cnt == CNT_W'(1));
    if (first) begin
      new_ent.qmin = qt;
      new_ent.qmax = qt;
      new_ent.emin = et;
      new_ent.emax = et;
    end else begin
      if (qt < old_ent.qmin) new_ent.qmin = qt;
      if (qt > old_ent.qmax) new_ent.qmax = qt;
      if (et < old_ent.emin) new_ent.emin = et;
      if (et > old_ent.emax) new_ent.emax = et;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      ent <= record ? new_ent : old_ent;
    end
  end

  assign div_start = (state == S_DGO);

  lts_div u_qdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ent.qsum),
    .divisor  (ent.cnt),
    .done     (qdiv_done),
    .quotient (qquo)
  );

  lts_div u_ediv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ent.esum),
    .divisor  (ent.cnt),
    .done     (ediv_done),
    .quotient (equo)
  );

  // Sequencer, totals and status history.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      imm_total <= '0;
      def_total <= '0;
      ls_start  <= '0;
      ls_done   <= '0;
      ls_exec   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) state <= S_PREP;
        end
        S_PREP: state <= S_ADJ;
        S_ADJ:  state <= S_UPD;
        S_UPD: begin
          if (record) begin
            imm_total <= (imm_total == '1) ? imm_total : imm_total + 1'b1;
            if (is_status) begin
              ls_start <= sta;
              ls_done  <= fin;
              ls_exec  <= et;
            end
          end
          if (req == REQ_DEFERRED) begin
            def_total <= (def_total == '1) ? def_total : def_total + 1'b1;
          end
          if (tvalid) begin
            state <= S_DGO;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DGO: state <= S_DWT;
        S_DWT: begin
          if (qdiv_done && ediv_done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result registers, loaded together with done, so they are valid while done is high.
  always_ff @(posedge clk) begin
    if (state == S_UPD && !tvalid) begin
      type_valid      <= 1'b0;
      executed_count  <= '0;
      avg_queue       <= '0;
      min_queue       <= '0;
      max_queue       <= '0;
      avg_exec        <= '0;
      min_exec        <= '0;
      max_exec        <= '0;
      total_immediate <= imm_total;
      total_deferred  <= (req == REQ_DEFERRED && def_total != '1) ?
                         def_total + 1'b1 : def_total;
    end else if (state == S_DWT && qdiv_done && ediv_done) begin
      type_valid      <= 1'b1;
      executed_count  <= ent.cnt;
      if (ent.cnt == '0) begin
        avg_queue <= '0;
        avg_exec  <= '0;
      end else begin
        avg_queue <= OUT_W'((qquo > TIME_MAX) ? TIME_MAX : qquo);
        avg_exec  <= OUT_W'((equo > TIME_MAX) ? TIME_MAX : equo);
      end
      min_queue       <= OUT_W'(ent.qmin);
      max_queue       <= OUT_W'(ent.qmax);
      min_exec        <= OUT_W'(ent.emin);
      max_exec        <= OUT_W'(ent.emax);
      total_immediate <= imm_total;
      total_deferred  <= def_total;
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the per-type latency statistics block.
`timescale 1ns / 1ps
module testbench;
  import lts_pkg::*;

  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]        req;
    logic [TYPE_W-1:0] ev;
    logic [47:0]       cre;
    logic [47:0]       sta;
    logic [47:0]       fin;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] count;
    logic [47:0] aq, nq, xq, ae, ne, xe;
    logic [31:0] imm, dfr;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = '0;
  logic [TYPE_W-1:0] event_type = '0;
  logic [47:0] creation_time = '0, start_time = '0, completion_time = '0;
  logic done, type_valid;
  logic [31:0] executed_count, total_immediate, total_deferred;
  logic [47:0] avg_queue, min_queue, max_queue, avg_exec, min_exec, max_exec;

  per_type_latency_statistics u_top (.*);

  always #2 clk = ~clk;

  // Predictor state.
  logic [31:0] cnt_q [64];
  logic [63:0] qsum [64], esum [64];
  logic [47:0] qmin [64], qmax [64], emin [64], emax [64];
  logic [31:0] imm_tot, dfr_tot;
  logic [47:0] st_start, st_done, st_exec;
  logic [5:0]  status_idx;

  cmd_t   pending [$];
  stats_t expected_stats [$];
  int     errors = 0;
  bit     quiet = 0;
  bit     take = 0;

  function automatic logic [47:0] sub0(logic [47:0] a, logic [47:0] b);
    return (a > b) ? a - b : 48'd0;
  endfunction

  function automatic logic [47:0] mean(logic [63:0] s, logic [31:0] c);
    logic [63:0] q;
    if (c == 0) return 48'd0;
    q = s / {32'd0, c};
    return (q > {16'd0, T_MAX}) ? T_MAX : q[47:0];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [47:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic stats_t apply_cmd(cmd_t c);
    stats_t r;
    logic [47:0] qt, et;
    int t;
    bit ok, is_st;
    ok = c.ev < 64;
    t = ok ? c.ev : 0;
    if (c.req == REQ_IMMEDIATE && ok) begin
      qt = sub0(c.sta, c.cre);
      et = sub0(c.fin, c.sta);
      is_st = (t == status_idx);
      if (!is_st && st_done > c.cre) begin
        if (st_start >= c.cre) qt = sub0(qt, st_exec);
        else qt = sub0(qt, st_done - c.cre);
      end
      if (imm_tot != '1) imm_tot++;
      if (cnt_q[t] != '1) cnt_q[t]++;
      qsum[t] = add_sat(qsum[t], qt);
      esum[t] = add_sat(esum[t], et);
      if (cnt_q[t] == 1) begin
        qmin[t] = qt; qmax[t] = qt; emin[t] = et; emax[t] = et;
      end else begin
        if (qt < qmin[t]) qmin[t] = qt;
        if (qt > qmax[t]) qmax[t] = qt;
        if (et < emin[t]) emin[t] = et;
        if (et > emax[t]) emax[t] = et;
      end
      if (is_st) begin
        st_start = c.sta; st_done = c.fin; st_exec = et;
      end
    end else if (c.req == REQ_DEFERRED) begin
      if (dfr_tot != '1) dfr_tot++;
    end
    r = '0;
    r.valid = ok;
    if (ok) begin
      r.count = cnt_q[t];
      r.aq = mean(qsum[t], cnt_q[t]);
      r.nq = qmin[t]; r.xq = qmax[t];
      r.ae = mean(esum[t], cnt_q[t]);
      r.ne = emin[t]; r.xe = emax[t];
    end
    r.imm = imm_tot;
    r.dfr = dfr_tot;
    return r;
  endfunction

  // Driver: one command at a time, with random idle cycles between them unless quiet is set.
  // busy only changes at the rising edge, so a command offered while busy is
  // low is taken at the next rising edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (take) begin
        expected_stats.push_back(apply_cmd(pending[0]));
        pending.pop_front();
      end
      if (pending.size() != 0 && (quiet || $urandom_range(99) >= 11)) begin
        start <= 1'b1;
        req_type <= pending[0].req;
        event_type <= pending[0].ev;
        creation_time <= pending[0].cre;
        start_time <= pending[0].sta;
        completion_time <= pending[0].fin;
        take = !busy;
      end else begin
        start <= 1'b0;
        take = 1'b0;
      end
    end
  end

  // Monitor: every done pulse is one result transfer.
  always @(posedge clk) begin
    stats_t got, exp_r;
    if (!rst && done) begin
      got = {type_valid, executed_count, avg_queue, min_queue, max_queue,
             avg_exec, min_exec, max_exec, total_immediate, total_deferred};
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_stats.pop_front();
        if (got.valid !== exp_r.valid || got.count !== exp_r.count ||
            got.aq !== exp_r.aq || got.nq !== exp_r.nq || got.xq !== exp_r.xq ||
            got.ae !== exp_r.ae || got.ne !== exp_r.ne || got.xe !== exp_r.xe ||
            got.imm !== exp_r.imm || got.dfr !== exp_r.dfr) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
          errors++;
        end
      end
    end
  end

  function automatic logic [47:0] rnd48();
    return {$urandom(), $urandom()} & T_MAX;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    logic [47:0] base;
    int k;
    k = $urandom_range(99);
    c.req = (k < 60) ? REQ_IMMEDIATE : (k < 75) ? REQ_DEFERRED :
            (k < 95) ? REQ_READ : 2'd3;
    c.ev = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 64)) :
           ($urandom_range(2) == 0) ? {2'b00, status_idx} : 8'($urandom_range(7));
    if ($urandom_range(15) == 0) begin
      c.cre = rnd48(); c.sta = rnd48(); c.fin = rnd48();
    end else begin
      base = rnd48() >> $urandom_range(47);
      c.cre = base + $urandom_range(200);
      c.sta = base + $urandom_range(400, 100);
      c.fin = c.sta + $urandom_range(300);
    end
    return c;
  endfunction

  task automatic apb_write(logic [DATA_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_STATUS_TYPE; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    status_idx = v[5:0];
  endtask

  task automatic drain();
    while (pending.size() != 0 || expected_stats.size() != 0 || start) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  initial begin
    int n;
    for (int i = 0; i < 64; i++) begin
      cnt_q[i] = 0; qsum[i] = 0; esum[i] = 0;
      qmin[i] = 0; qmax[i] = 0; emin[i] = 0; emax[i] = 0;
    end
    imm_tot = 0; dfr_tot = 0; st_start = 0; st_done = 0; st_exec = 0; status_idx = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: empty reads, extremes, negative differences, status overlap.
    pending.push_back('{REQ_READ, 8'd5, 48'd0, 48'd0, 48'd0});
    pending.push_back('{REQ_IMMEDIATE, 8'd0, 48'd100, 48'd200, 48'd500});
    pending.push_back('{REQ_IMMEDIATE, 8'd1, 48'd150, 48'd600, 48'd700});
    pending.push_back('{REQ_IMMEDIATE, 8'd1, 48'd50, 48'd400, 48'd450});
    pending.push_back('{REQ_IMMEDIATE, 8'd1, 48'd300, 48'd200, 48'd100});
    pending.push_back('{REQ_IMMEDIATE, 8'd2, 48'd0, T_MAX, T_MAX});
    pending.push_back('{REQ_IMMEDIATE, 8'd2, 48'd0, T_MAX, 48'd0});
    pending.push_back('{REQ_IMMEDIATE, 8'd63, T_MAX, 48'd0, T_MAX});
    pending.push_back('{REQ_IMMEDIATE, 8'd64, 48'd1, 48'd2, 48'd3});
    pending.push_back('{REQ_IMMEDIATE, 8'd255, 48'd1, 48'd2, 48'd3});
    pending.push_back('{REQ_DEFERRED, 8'd200, T_MAX, T_MAX, T_MAX});
    pending.push_back('{REQ_DEFERRED, 8'd3, 48'd0, 48'd0, 48'd0});
    pending.push_back('{2'd3, 8'd1, 48'd0, 48'd0, 48'd0});
    pending.push_back('{REQ_READ, 8'd2, 48'd0, 48'd0, 48'd0});
    pending.push_back('{REQ_READ, 8'd64, 48'd0, 48'd0, 48'd0});
    drain();
    apb_write(32'd63);
    pending.push_back('{REQ_IMMEDIATE, 8'd63, 48'd1000, 48'd1100, 48'd1500});
    pending.push_back('{REQ_IMMEDIATE, 8'd0, 48'd900, 48'd1600, 48'd1700});
    pending.push_back('{REQ_IMMEDIATE, 8'd0, 48'd1200, 48'd1600, 48'd1700});
    pending.push_back('{REQ_READ, 8'd0, T_MAX, T_MAX, T_MAX});
    drain();
    // Random phases, each with its own status type; one phase without idling.
    for (int ph = 0; ph < 8; ph++) begin
      apb_write(ph == 0 ? 32'd0 : ph == 1 ? 32'd63 : {$urandom()} | 32'hFFFF_FFC0 &
                $urandom());
      quiet = (ph == 3);
      n = (ph == 0 || ph == 1) ? 100 : 230;
      repeat (n) pending.push_back(rand_cmd());
      drain();
    end
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/lts_pkg.sv
rtl/lts_div.sv
rtl/per_type_latency_statistics.sv
verif/testbench.sv
